[hdl/tte_pkg.sv]
package tte_pkg;

   // Field widths
   localparam int TEMPO_W = 12;
   localparam int TIME_W = 32;
   localparam int GAP_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   // Default tap history depth
   localparam int TAP_WINDOW_DEFAULT = 6;

   // Beats per minute in tenths from milliseconds
   localparam int TEMPO_NUMERATOR = 600000;

   // Reset values
   localparam logic [TEMPO_W-1:0] RESET_TEMPO = TEMPO_W'(1200);
   localparam logic [TEMPO_W-1:0] RESET_MIN_TEMPO = TEMPO_W'(400);
   localparam logic [TEMPO_W-1:0] RESET_MAX_TEMPO = TEMPO_W'(2400);
   localparam logic [GAP_W-1:0] RESET_GAP_MS = GAP_W'(2000);

   // Command codes
   typedef enum logic {
      CMD_TAP = 1'b0,
      CMD_SET_TEMPO = 1'b1
   } command_type;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MIN_TEMPO = 2'd0,
      REG_MAX_TEMPO = 2'd1,
      REG_RESET_GAP = 2'd2
   } reg_index_type;

endpackage

[hdl/tte_if.sv]
interface tte_req_if import tte_pkg::*; ();
   logic valid;
   logic ready;
   logic command;
   logic [TIME_W-1:0] tap_time_ms;
   logic [TEMPO_W-1:0] typed_tempo_tenths;

   modport source (output valid, command, tap_time_ms, typed_tempo_tenths, input ready);
   modport sink (input valid, command, tap_time_ms, typed_tempo_tenths, output ready);
endinterface

interface tte_rsp_if import tte_pkg::*; ();
   logic valid;
   logic ready;
   logic [TEMPO_W-1:0] tempo_tenths;
   logic tempo_updated;

   modport source (output valid, tempo_tenths, tempo_updated, input ready);
   modport sink (input valid, tempo_tenths, tempo_updated, output ready);
endinterface

[hdl/tte_div.sv]
module tte_div import tte_pkg::*; #(
   parameter int DIVIDEND_W = 22
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [TIME_W-1:0]     divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [TIME_W-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [TIME_W-1:0]     dsor_ff, dsor_in;
   logic [TIME_W:0]       trial;
   logic [TIME_W:0]       diff;
   logic                  fits;

   // Restoring divide: one quotient bit per cycle
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff = trial - {1'b0, dsor_ff};
      fits = (trial >= {1'b0, dsor_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsor_in = dsor_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(DIVIDEND_W);
         rem_in = '0;
         quo_in = dividend;
         dsor_in = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsor_ff <= dsor_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

[hdl/tap_tempo_estimator.sv]
// Channel  Direction  Payload
// req_     in         command, tap_time_ms, typed_tempo_tenths
// rsp_     out        tempo_tenths, tempo_updated
// csr_     in         csr_index, csr_wdata under csr_we
//
// A tap that yields a new tempo goes from S_IDLE to S_DIV, where the
// bit-serial divider forms the tempo, and then to S_EMIT, which loads
// the response register; the next transaction is taken once the
// sequencer is back in S_IDLE. A typed tempo or a tap without a division
// goes from S_IDLE straight to S_EMIT.
// Reset is synchronous; the tap history holds no reset value and is read
// only below the tap count. One transaction is in flight at a time; a held
// result blocks completion of the next one until rsp_chan.ready.
module tap_tempo_estimator import tte_pkg::*; #(
   parameter int TAP_WINDOW = TAP_WINDOW_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   tte_req_if.sink                req_chan,
   tte_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CNT_W = $clog2(TAP_WINDOW + 1);
   localparam int IDX_W = $clog2(TAP_WINDOW);
   localparam int DIVIDEND_W = $clog2(TEMPO_NUMERATOR * (TAP_WINDOW - 1) + 1);
   localparam logic [DIVIDEND_W-1:0] NUMERATOR = DIVIDEND_W'(TEMPO_NUMERATOR);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [TIME_W-1:0]     hist_ff [TAP_WINDOW];
   logic [TIME_W-1:0]     hist_in [TAP_WINDOW];
   logic [TIME_W-1:0]     last_ff, last_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [TEMPO_W-1:0]    tempo_ff, tempo_in;
   logic                  upd_ff, upd_in;
   logic [TEMPO_W-1:0]    min_ff, min_in;
   logic [TEMPO_W-1:0]    max_ff, max_in;
   logic [GAP_W-1:0]      gap_ff, gap_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TEMPO_W-1:0]    rsp_tempo_ff, rsp_tempo_in;
   logic                  rsp_upd_ff, rsp_upd_in;

   logic                  accept;
   logic [TIME_W-1:0]     gap_c;
   logic [CNT_W-1:0]      count_eff;
   logic                  full_c;
   logic [CNT_W-1:0]      new_n;
   logic [TIME_W-1:0]     oldest;
   logic [TIME_W-1:0]     span;
   logic                  do_div;
   logic [DIVIDEND_W-1:0] dividend;
   logic                  div_start;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] div_quo;

   function automatic logic [TEMPO_W-1:0] clamp_tempo(
      input logic [DIVIDEND_W-1:0] v,
      input logic [TEMPO_W-1:0] lo,
      input logic [TEMPO_W-1:0] hi
   );
      logic [TEMPO_W-1:0] r;
      if (v < DIVIDEND_W'(lo)) begin
         r = lo;
      end else if (v > DIVIDEND_W'(hi)) begin
         r = hi;
      end else begin
         r = v[TEMPO_W-1:0];
      end
      return r;
   endfunction

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   // Tap bookkeeping: gap check, window fill, span to the oldest tap
   always_comb begin
      gap_c = req_chan.tap_time_ms - last_ff;
      count_eff = ((count_ff != '0) && (gap_c > TIME_W'(gap_ff))) ? '0 : count_ff;
      full_c = (count_eff == CNT_W'(TAP_WINDOW));
      new_n = full_c ? count_eff : count_eff + CNT_W'(1);
      if (full_c) begin
         oldest = hist_ff[1];
      end else if (count_eff == '0) begin
         oldest = req_chan.tap_time_ms;
      end else begin
         oldest = hist_ff[0];
      end
      span = req_chan.tap_time_ms - oldest;
      do_div = (new_n >= CNT_W'(2)) && (span != '0);
      dividend = NUMERATOR * DIVIDEND_W'(new_n - CNT_W'(1));
   end

   assign div_start = accept && (req_chan.command == CMD_TAP) && do_div;

   tte_div #(
      .DIVIDEND_W (DIVIDEND_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (span),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Sequencer and register updates
   always_comb begin
      state_in = state_ff;
      hist_in = hist_ff;
      last_in = last_ff;
      count_in = count_ff;
      tempo_in = tempo_ff;
      upd_in = upd_ff;
      min_in = min_ff;
      max_in = max_ff;
      gap_in = gap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_tempo_in = rsp_tempo_ff;
      rsp_upd_in = rsp_upd_ff;

      // Take register writes
      if (csr_we) begin
         unique case (csr_index)
            REG_MIN_TEMPO: min_in = csr_wdata[TEMPO_W-1:0];
            REG_MAX_TEMPO: max_in = csr_wdata[TEMPO_W-1:0];
            REG_RESET_GAP: gap_in = csr_wdata[GAP_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EMIT;
               if (req_chan.command == CMD_SET_TEMPO) begin
                  tempo_in = clamp_tempo(DIVIDEND_W'(req_chan.typed_tempo_tenths),
                                         min_ff, max_ff);
                  count_in = '0;
                  upd_in = 1'b1;
               end else begin
                  // Append the tap, shifting out the oldest when full
                  if (full_c) begin
                     for (int i = 0; i < TAP_WINDOW - 1; i++) begin
                        hist_in[i] = hist_ff[i+1];
                     end
                     hist_in[TAP_WINDOW-1] = req_chan.tap_time_ms;
                  end else begin
                     hist_in[count_eff[IDX_W-1:0]] = req_chan.tap_time_ms;
                  end
                  last_in = req_chan.tap_time_ms;
                  count_in = new_n;
                  upd_in = do_div;
                  if (do_div) begin
                     state_in = S_DIV;
                  end
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               tempo_in = clamp_tempo(div_quo, min_ff, max_ff);
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_tempo_in = tempo_ff;
               rsp_upd_in = upd_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         tempo_ff <= RESET_TEMPO;
         upd_ff <= 1'b0;
         min_ff <= RESET_MIN_TEMPO;
         max_ff <= RESET_MAX_TEMPO;
         gap_ff <= RESET_GAP_MS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         tempo_ff <= tempo_in;
         upd_ff <= upd_in;
         min_ff <= min_in;
         max_ff <= max_in;
         gap_ff <= gap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hist_ff <= hist_in;
      last_ff <= last_in;
      rsp_tempo_ff <= rsp_tempo_in;
      rsp_upd_ff <= rsp_upd_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.tempo_tenths = rsp_tempo_ff;
   assign rsp_chan.tempo_updated = rsp_upd_ff;

endmodule
